@@ sv/bal_pkg.sv @@
// Package for the bounded array list: sizes, codes, beat types and sequencer states.
`default_nettype none
package bal_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;

  localparam logic [2:0] ACT_APPEND    = 3'd0;
  localparam logic [2:0] ACT_INS_FRONT = 3'd1;
  localparam logic [2:0] ACT_REM_FIRST = 3'd2;
  localparam logic [2:0] ACT_REM_LAST  = 3'd3;
  localparam logic [2:0] ACT_INS_POS   = 3'd4;
  localparam logic [2:0] ACT_READ      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]        action;
    logic [6:0]        position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [6:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DOWN,
    S_FIN
  } state_e;

endpackage
`default_nettype wire

@@ sv/bal_ram.sv @@
// Entry store: one write port, one read port, registered read data.
`default_nettype none
module bal_ram (
  input  wire                    clk_i,
  input  wire bal_pkg::mem_req_t mem_req_i,
  output logic [31:0]            rdata_o
);
  import bal_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_o <= mem[mem_req_i.raddr];
  end

endmodule
`default_nettype wire

@@ sv/bal_ctrl.sv @@
// Request sequencer: checks, shifts entries through the store and builds the reply.
`default_nettype none
module bal_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire bal_pkg::req_t req_i,
  output logic               done_o,
  output bal_pkg::rsp_t      rsp_o,
  output bal_pkg::mem_req_t  mem_req_o,
  input  wire [31:0]         rdata_i
);
  import bal_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] wa_q, wa_d;
  logic [ADDR_W-1:0] at_q, at_d;
  logic              pend_q, pend_d;
  logic              first_q, first_d;
  logic              cap_q, cap_d;
  logic [1:0]        st_q, st_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;
  logic [CNT_W-1:0]  at_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    ptr_q   <= ptr_d;
    wa_q    <= wa_d;
    at_q    <= at_d;
    first_q <= first_d;
    cap_q   <= cap_d;
    st_q    <= st_d;
    res_q   <= res_d;
    val_q   <= val_d;
    rsp_q   <= rsp_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    ptr_d   = ptr_q;
    wa_d    = wa_q;
    at_d    = at_q;
    pend_d  = pend_q;
    first_d = first_q;
    cap_d   = cap_q;
    st_d    = st_q;
    res_d   = res_q;
    val_d   = val_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    at_w    = cnt_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = wa_q;
    mem_req_o.wdata = rdata_i;
    mem_req_o.raddr = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          val_d   = req_i.item_value;
          res_d   = '0;
          st_d    = ST_OK;
          pend_d  = 1'b0;
          first_d = 1'b1;
          cap_d   = 1'b0;
          state_d = S_FIN;
          case (req_i.action)
            ACT_APPEND, ACT_INS_FRONT, ACT_INS_POS: begin
              if (req_i.action == ACT_INS_FRONT) begin
                at_w = '0;
              end else if (req_i.action == ACT_INS_POS) begin
                at_w = req_i.position;
              end
              if (cnt_q == CNT_W'(CAPACITY)) begin
                st_d = ST_FULL;
              end else if (at_w > cnt_q) begin
                st_d = ST_RANGE;
              end else begin
                at_d    = at_w[ADDR_W-1:0];
                n_d     = cnt_q - at_w;
                ptr_d   = ADDR_W'(cnt_q - CNT_W'(1));
                cnt_d   = cnt_q + CNT_W'(1);
                state_d = S_UP;
              end
            end
            ACT_REM_FIRST, ACT_REM_LAST: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                if (req_i.action == ACT_REM_FIRST) begin
                  ptr_d = '0;
                  n_d   = cnt_q;
                end else begin
                  ptr_d = ADDR_W'(cnt_q - CNT_W'(1));
                  n_d   = CNT_W'(1);
                end
                cnt_d   = cnt_q - CNT_W'(1);
                state_d = S_DOWN;
              end
            end
            ACT_READ: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else if (req_i.position >= cnt_q) begin
                st_d = ST_RANGE;
              end else begin
                ptr_d   = req_i.position[ADDR_W-1:0];
                n_d     = CNT_W'(1);
                state_d = S_DOWN;
              end
            end
            default: begin
              st_d = ST_OK;
            end
          endcase
        end
      end
      S_UP: begin
        // Each cycle writes the entry read last cycle one place up and reads the next lower one.
        if (pend_q) begin
          mem_req_o.we = 1'b1;
        end
        if (n_q != '0) begin
          wa_d   = ptr_q + ADDR_W'(1);
          pend_d = 1'b1;
          ptr_d  = ptr_q - ADDR_W'(1);
          n_d    = n_q - CNT_W'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = at_q;
        mem_req_o.wdata = val_q;
        done_d          = 1'b1;
        rsp_d           = '{status: st_q, result_value: res_q, entry_count: cnt_q};
        state_d         = S_IDLE;
      end
      S_DOWN: begin
        // The first read is the reply value; later reads move one place down.
        if (pend_q) begin
          if (cap_q) begin
            res_d = rdata_i;
          end else begin
            mem_req_o.we = 1'b1;
          end
        end
        if (n_q != '0) begin
          wa_d    = ptr_q - ADDR_W'(1);
          cap_d   = first_q;
          first_d = 1'b0;
          pend_d  = 1'b1;
          ptr_d   = ptr_q + ADDR_W'(1);
          n_d     = n_q - CNT_W'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        done_d  = 1'b1;
        rsp_d   = '{status: st_q, result_value: res_q, entry_count: cnt_q};
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("reply strobe held for two cycles");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY)) else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted request left sequencer idle");

  a_idle_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_req_o.we) else $error("store written while idle");

endmodule
`default_nettype wire

@@ sv/bounded_array_list.sv @@
// Top level of the bounded array list: sequencer plus entry store.
//
// A request beat (action, position, item_value) is taken at a rising clock
// edge where start is high and busy is low. Busy rises the cycle after and
// stays high while the request runs. Every request returns exactly one reply
// beat (status, result_value, entry_count) on rsp_o, marked by done_o for a
// single cycle. The receiver cannot stall, so the reply must be taken when
// done_o is high; a new request may be started in that same cycle.
//
// The time to done_o grows with the entries that a request must shift: an
// insert at position p moves the c - p entries at and above it up (append
// moves none), remove first moves every entry but the first down, remove last
// and read make a single read, and rejected or unused requests go straight
// to the reply. This is set by the single read and single write port of the
// store: every shifted entry takes a read and a write through it.
//
// Reset clears the count and the sequencer; the store itself is not cleared,
// since no entry's read data is used before it has been written.
`default_nettype none
module bounded_array_list (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire bal_pkg::req_t req_i,
  output logic               done_o,
  output bal_pkg::rsp_t      rsp_o
);
  import bal_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rdata;

  // Sequencer owns the count, the reply register and all store accesses.
  bal_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .rdata_i   (rdata)
  );

  // Entry store with registered read data.
  bal_ram u_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

endmodule
`default_nettype wire

@@ dv/bal_checker.sv @@
// Scoreboard for the bounded array list: follows request beats, predicts the reply, checks it.
module bal_checker (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire           busy_i,
  input  bal_pkg::req_t req_i,
  input  wire           done_i,
  input  bal_pkg::rsp_t rsp_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            reply_count_o,
  output int            full_count_o,
  output int            empty_count_o,
  output int            range_count_o,
  output int            peak_o
);
  import bal_pkg::*;

  localparam int SHOWN_MISMATCHES = 10;

  // Shadow copy of the list.
  logic signed [DATA_W-1:0] held [CAPACITY];
  int unsigned              held_count;

  bal_pkg::rsp_t replies_due[$];
  bal_pkg::rsp_t want;
  int            fails;
  int            replies;
  int            fulls;
  int            empties;
  int            ranges;
  int            peak;

  // Applies one request to the shadow list and returns the reply it must produce.
  function automatic bal_pkg::rsp_t list_apply(bal_pkg::req_t r);
    bal_pkg::rsp_t o;
    int unsigned   slot;
    int unsigned   i;
    o.status       = ST_OK;
    o.result_value = '0;
    case (r.action)
      ACT_APPEND, ACT_INS_FRONT, ACT_INS_POS: begin
        if (held_count >= CAPACITY) begin
          // A full list is reported before the position is looked at.
          o.status = ST_FULL;
        end else begin
          if (r.action == ACT_APPEND) slot = held_count;
          else if (r.action == ACT_INS_FRONT) slot = 0;
          else slot = r.position;
          if (slot > held_count) begin
            o.status = ST_RANGE;
          end else begin
            for (i = held_count; i > slot; i--) held[i] = held[i-1];
            held[slot] = r.item_value;
            held_count++;
          end
        end
      end
      ACT_REM_FIRST: begin
        if (held_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.result_value = held[0];
          for (i = 0; i + 1 < held_count; i++) held[i] = held[i+1];
          held_count--;
        end
      end
      ACT_REM_LAST: begin
        if (held_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.result_value = held[held_count-1];
          held_count--;
        end
      end
      ACT_READ: begin
        if (held_count == 0) o.status = ST_EMPTY;
        else if (r.position >= held_count) o.status = ST_RANGE;
        else o.result_value = held[r.position];
      end
      default: begin
      end
    endcase
    o.entry_count = held_count[CNT_W-1:0];
    if (held_count > peak) peak = held_count;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count = 0;
      replies_due.delete();
      fails   = 0;
      replies = 0;
      fulls   = 0;
      empties = 0;
      ranges  = 0;
      peak    = 0;
    end else begin
      // The reply is checked before a request taken at the same edge is queued,
      // so a stray reply can never be matched against that new request.
      if (done_i) begin
        replies++;
        if (replies_due.size() == 0) begin
          fails++;
          if (fails <= SHOWN_MISMATCHES)
            $display("reply beat with nothing outstanding: status %0d value %0d count %0d",
                     rsp_i.status, rsp_i.result_value, rsp_i.entry_count);
        end else begin
          want = replies_due.pop_front();
          case (want.status)
            ST_FULL:  fulls++;
            ST_EMPTY: empties++;
            ST_RANGE: ranges++;
            default: begin
            end
          endcase
          if (rsp_i.status !== want.status || rsp_i.result_value !== want.result_value ||
              rsp_i.entry_count !== want.entry_count) begin
            fails++;
            if (fails <= SHOWN_MISMATCHES)
              $display("reply %0d mismatch: expected status %0d value %0d count %0d, got status %0d value %0d count %0d",
                       replies, want.status, want.result_value, want.entry_count,
                       rsp_i.status, rsp_i.result_value, rsp_i.entry_count);
          end
        end
      end
      if (start_i && !busy_i) replies_due.push_back(list_apply(req_i));
    end
    fail_count_o  <= fails;
    pending_o     <= replies_due.size();
    reply_count_o <= replies;
    full_count_o  <= fulls;
    empty_count_o <= empties;
    range_count_o <= ranges;
    peak_o        <= peak;
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the bounded array list: clock, reset, request stimulus and verdict.
module tb;
  import bal_pkg::*;

  // The two action codes the block leaves unused; they must act as no-ops.
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS   = 800;
  // The limit lies above the longest request and the longest sender gap, so
  // running into it can only mean the block has hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles to linger after the last reply, a little over the worst latency.
  localparam int TAIL_CYCLES    = 80;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX,
    MODE_NOISE
  } mode_e;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  bal_pkg::req_t req_i;
  logic          done_o;
  bal_pkg::rsp_t rsp_o;

  int fail_count;
  int pending;
  int reply_count;
  int full_count;
  int empty_count;
  int range_count;
  int peak;

  bounded_array_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  bal_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_i         (req_i),
    .done_i        (done_o),
    .rsp_i         (rsp_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .reply_count_o (reply_count),
    .full_count_o  (full_count),
    .empty_count_o (empty_count),
    .range_count_o (range_count),
    .peak_o        (peak)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bal_pkg::req_t make_req(logic [2:0] act, logic [6:0] pos,
                                             logic [31:0] val);
    bal_pkg::req_t r;
    r.action     = act;
    r.position   = pos;
    r.item_value = val;
    return r;
  endfunction

  // Values lean on the signed extremes, zero and all ones now and then; otherwise every bit is random.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 15))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2:       v = 32'h0000_0000;
      3:       v = 32'hffff_ffff;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Positions are skewed toward the low end, where they are most often in
  // range, with the capacity itself and uniform picks up to it mixed in.
  function automatic logic [6:0] pick_position();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return 7'($urandom_range(0, $urandom_range(0, CAPACITY)));
    if (roll < 9) return 7'($urandom_range(0, CAPACITY));
    return 7'(CAPACITY);
  endfunction

  // One random request beat, shaped by the current mode: fill mode grows the
  // list until it is full, drain mode empties it, mix mode is even, and noise
  // mode also throws in the unused action codes.
  function automatic bal_pkg::req_t pick_request(mode_e mode);
    int         roll;
    logic [2:0] act;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (roll < 35) act = ACT_APPEND;
        else if (roll < 60) act = ACT_INS_FRONT;
        else if (roll < 85) act = ACT_INS_POS;
        else if (roll < 92) act = ACT_READ;
        else if (roll < 96) act = ACT_REM_FIRST;
        else act = ACT_REM_LAST;
      end
      MODE_DRAIN: begin
        if (roll < 35) act = ACT_REM_FIRST;
        else if (roll < 70) act = ACT_REM_LAST;
        else if (roll < 85) act = ACT_READ;
        else if (roll < 90) act = ACT_APPEND;
        else if (roll < 95) act = ACT_INS_FRONT;
        else act = ACT_INS_POS;
      end
      MODE_MIX: act = 3'($urandom_range(0, 5));
      default:  act = 3'($urandom_range(0, 7));
    endcase
    return make_req(act, pick_position(), pick_value());
  endfunction

  // Presents one request beat and returns at the edge that takes it. Start is
  // left high, so the next beat can follow with no gap; whoever idles lowers it.
  // Busy is read right at the edge, which gives its value from before the edge.
  task automatic send(bal_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  // Stops sending and waits until the scoreboard holds no outstanding reply.
  // The first cycle lets the count take in a beat accepted at this very edge.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Watchdog: any cycle that moves a request or a reply beat restarts it.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int    sent;
    int    seg_left;
    int    seg_idx;
    int    burst_left;
    int    gap;
    mode_e mode;

    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. On the empty list every removal and read must report
    // empty, and an insert past the end must report out of range.
    send(make_req(ACT_READ,      7'd0,  32'd0));
    send(make_req(ACT_REM_FIRST, 7'd0,  32'd0));
    send(make_req(ACT_REM_LAST,  7'd0,  32'd0));
    send(make_req(ACT_INS_POS,   7'd1,  32'd5));
    // Unused actions change nothing, whatever the other fields hold.
    send(make_req(ACT_SPARE_LO,  7'd3,  32'hffff_ffff));
    send(make_req(ACT_SPARE_HI,  7'd64, 32'h1234_5678));
    // Build a short list from the signed extremes and all ones.
    send(make_req(ACT_APPEND,    7'd0,  32'h7fff_ffff));
    send(make_req(ACT_INS_FRONT, 7'd0,  32'h8000_0000));
    send(make_req(ACT_INS_POS,   7'd1,  32'hffff_ffff));
    // Inserting at a position equal to the count is an append.
    send(make_req(ACT_INS_POS,   7'd3,  32'h0000_0000));
    send(make_req(ACT_INS_POS,   7'd64, 32'h0000_0001));
    // Reads at both ends, just past the end, and at the capacity.
    send(make_req(ACT_READ,      7'd0,  32'd0));
    send(make_req(ACT_READ,      7'd3,  32'd0));
    send(make_req(ACT_READ,      7'd4,  32'd0));
    send(make_req(ACT_READ,      7'd64, 32'd0));
    // Position is ignored by the plain inserts and by the removals.
    send(make_req(ACT_APPEND,    7'h7f, 32'h5555_5555));
    send(make_req(ACT_INS_FRONT, 7'd64, 32'haaaa_aaaa));
    send(make_req(ACT_REM_FIRST, 7'd64, 32'hffff_ffff));
    send(make_req(ACT_REM_LAST,  7'd1,  32'd0));
    send(make_req(ACT_READ,      7'd2,  32'd0));
    send(make_req(ACT_REM_FIRST, 7'd0,  32'd0));
    send(make_req(ACT_REM_LAST,  7'd0,  32'd0));
    send(make_req(ACT_REM_FIRST, 7'd0,  32'd0));
    send(make_req(ACT_REM_LAST,  7'd0,  32'd0));
    wait_drained();

    // Random part, in segments. The first segment fills the list until it
    // rejects inserts, the second drains it until removals report empty,
    // and later segments pick their mode at random.
    sent       = 0;
    seg_idx    = 0;
    burst_left = $urandom_range(1, 30);
    while (sent < RANDOM_ITEMS) begin
      if (seg_idx == 0) mode = MODE_FILL;
      else if (seg_idx == 1) mode = MODE_DRAIN;
      else begin
        case ($urandom_range(0, 9))
          0, 1, 2: mode = MODE_FILL;
          3, 4:    mode = MODE_DRAIN;
          5, 6, 7: mode = MODE_MIX;
          default: mode = MODE_NOISE;
        endcase
      end
      seg_left = (seg_idx < 2) ? 150 : $urandom_range(40, 150);
      seg_idx++;
      while (seg_left > 0 && sent < RANDOM_ITEMS) begin
        send(pick_request(mode));
        sent++;
        seg_left--;
        burst_left--;
        // Between bursts the sender may go quiet; long gaps let the next start
        // land at any point of a request that shifts the whole list.
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
      // Sometimes hold off until every reply is back before the next segment.
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d replies: %0d full, %0d empty, %0d out of range, the rest ok.",
             reply_count, full_count, empty_count, range_count);
    $display("The list reached %0d of %0d entries; %0d failures seen.",
             peak, CAPACITY, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
